// ===== src/thc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the table Huffman codec.
// No dependencies; every other file but thc_ram uses this package.
package thc_pkg;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  localparam int OP_W    = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int POS_W   = $clog2(CODE_W);
  localparam int ENTRY_W = LEN_W + CODE_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ENCODE,
    CMD_DECODE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              bit_in;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_LOOK,
    ST_ENC_EMIT,
    ST_DEC_SCAN,
    ST_DEC_EMIT,
    ST_OVF
  } state_t;

  // Longest code the table can hold: codes are CODE_W bits wide.
  function automatic int longest_code(input int max_len);
    return (max_len < CODE_W) ? max_len : CODE_W;
  endfunction

endpackage

// ===== src/thc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/thc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, drops those with no effect,
// trims write codes and hands commands to the queue. Uses thc_pkg.
module thc_front #(
  parameter int MAX_CODE_LEN = thc_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = thc_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [thc_pkg::OP_W-1:0]   operation,
  input  logic [thc_pkg::SYM_W-1:0]  symbol,
  input  logic [thc_pkg::CODE_W-1:0] code_bits,
  input  logic [thc_pkg::LEN_W-1:0]  code_length,
  input  logic                       bit_in,
  input  logic                       q_full,
  output logic                       push,
  output thc_pkg::cmd_t              push_cmd
);
  import thc_pkg::*;

  localparam int LONGEST = longest_code(MAX_CODE_LEN);

  logic              sym_ok;
  logic              len_ok;
  logic              keep;
  logic [CODE_W-1:0] mask;

  assign item_stall = q_full;
  assign sym_ok     = {1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign len_ok     = code_length <= LEN_W'(LONGEST);
  assign mask       = CODE_W'((64'd1 << code_length) - 64'd1);

  always_comb begin
    unique case (operation)
      OP_WRITE:  keep = sym_ok && len_ok;
      OP_ENCODE: keep = sym_ok;
      OP_DECODE: keep = 1'b1;
      OP_NONE:   keep = 1'b0;
      default:   keep = 1'b0;
    endcase
  end

  always_comb begin
    push_cmd.symbol = symbol;
    push_cmd.code   = code_bits & mask;
    push_cmd.len    = code_length;
    push_cmd.bit_in = bit_in;
    unique case (operation)
      OP_WRITE:  push_cmd.kind = CMD_WRITE;
      OP_ENCODE: push_cmd.kind = CMD_ENCODE;
      default:   push_cmd.kind = CMD_DECODE;
    endcase
  end

  assign push = item_valid && !q_full && keep;

endmodule

// ===== src/thc_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Uses thc_pkg for the command type and depth.
module thc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  thc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output thc_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import thc_pkg::*;

  cmd_t           mem [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   cnt;
  logic           do_push;
  logic           do_pop;

  assign full    = cnt == (QAW + 1)'(QUEUE_DEPTH);
  assign empty   = cnt == '0;
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/thc_back.sv =====
`timescale 1ns / 1ps
// Back end: owns the code table, the decode accumulator and the result
// register. Uses thc_pkg and thc_ram.
module thc_back #(
  parameter int MAX_CODE_LEN = thc_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = thc_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  thc_pkg::cmd_t             q_head,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      is_symbol,
  output logic                      bit_out,
  output logic [thc_pkg::SYM_W-1:0] symbol_out,
  output logic                      last,
  output logic                      overflow
);
  import thc_pkg::*;

  localparam int AW      = $clog2(SYMBOL_COUNT);
  localparam int LONGEST = longest_code(MAX_CODE_LEN);
  localparam logic [AW-1:0] LAST_SYM = AW'(SYMBOL_COUNT - 1);

  state_t state;
  state_t state_next;

  logic [SYMBOL_COUNT-1:0] tbl_valid;
  logic                    valid_q;
  logic                    ram_we;
  logic [AW-1:0]           raddr;
  logic [ENTRY_W-1:0]      rdata;
  logic [CODE_W-1:0]       rd_code;
  logic [LEN_W-1:0]        rd_len;
  logic [LEN_W-1:0]        look_len;

  logic [CODE_W-1:0] acc;
  logic [LEN_W-1:0]  count;
  logic              acc_full;

  logic [CODE_W-1:0] enc_code;
  logic [POS_W-1:0]  pos;

  logic [AW-1:0] scan_idx;
  logic [AW-1:0] chk_sym;
  logic          chk;
  logic          hit;
  logic          scan_end;

  logic             slot_free;
  logic             out_load;
  logic             is_symbol_next;
  logic             bit_out_next;
  logic [SYM_W-1:0] symbol_out_next;
  logic             last_next;
  logic             overflow_next;

  thc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.symbol[AW-1:0]),
    .wdata ({q_head.len, q_head.code}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_code   = rdata[CODE_W-1:0];
  assign rd_len    = rdata[ENTRY_W-1:CODE_W];
  assign look_len  = valid_q ? rd_len : '0;
  assign acc_full  = count >= LEN_W'(LONGEST);
  assign hit       = chk && (look_len == count) && (rd_code == acc);
  assign scan_end  = chk && (chk_sym == LAST_SYM);
  assign slot_free = !result_valid || !result_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.kind)
            CMD_ENCODE: state_next = ST_ENC_LOOK;
            CMD_DECODE: state_next = acc_full ? ST_OVF : ST_DEC_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ENC_LOOK: state_next = (look_len == '0) ? ST_IDLE : ST_ENC_EMIT;
      ST_ENC_EMIT: begin
        if (slot_free && pos == '0) begin
          state_next = ST_IDLE;
        end
      end
      ST_DEC_SCAN: begin
        priority if (hit) begin
          state_next = ST_DEC_EMIT;
        end else if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_DEC_EMIT, ST_OVF: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop             = (state == ST_IDLE) && !q_empty;
    ram_we          = pop && (q_head.kind == CMD_WRITE);
    raddr           = (state == ST_IDLE) ? q_head.symbol[AW-1:0] : scan_idx;
    out_load        = 1'b0;
    is_symbol_next  = 1'b0;
    bit_out_next    = 1'b0;
    symbol_out_next = '0;
    last_next       = 1'b0;
    overflow_next   = 1'b0;
    unique case (state)
      ST_ENC_EMIT: begin
        out_load     = slot_free;
        bit_out_next = enc_code[pos];
        last_next    = pos == '0;
      end
      ST_DEC_EMIT: begin
        out_load        = slot_free;
        is_symbol_next  = 1'b1;
        symbol_out_next = SYM_W'(chk_sym);
      end
      ST_OVF: begin
        out_load      = slot_free;
        overflow_next = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tbl_valid    <= '0;
      acc          <= '0;
      count        <= '0;
      chk          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        tbl_valid[q_head.symbol[AW-1:0]] <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop && q_head.kind == CMD_DECODE) begin
        chk <= 1'b0;
        if (acc_full) begin
          acc   <= '0;
          count <= '0;
        end else begin
          acc   <= {acc[CODE_W-2:0], q_head.bit_in};
          count <= count + 1'b1;
        end
      end else if (state == ST_DEC_SCAN) begin
        chk <= 1'b1;
        if (hit) begin
          acc   <= '0;
          count <= '0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    valid_q <= tbl_valid[raddr];
    if (state == ST_ENC_LOOK) begin
      enc_code <= rd_code;
      pos      <= POS_W'(look_len - 1'b1);
    end else if (state == ST_ENC_EMIT && out_load) begin
      pos <= pos - 1'b1;
    end
    if (pop) begin
      scan_idx <= '0;
    end else if (state == ST_DEC_SCAN && !hit && !scan_end) begin
      chk_sym <= scan_idx;
      if (scan_idx != LAST_SYM) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (out_load) begin
      is_symbol  <= is_symbol_next;
      bit_out    <= bit_out_next;
      symbol_out <= symbol_out_next;
      last       <= last_next;
      overflow   <= overflow_next;
    end
  end

endmodule

// ===== src/table_huffman_codec.sv =====
`timescale 1ns / 1ps
// Top level of the table-driven Huffman codec: front end, command queue
// and back end. Uses thc_pkg, thc_front, thc_queue, thc_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------------
//   item    | item_valid / item_stall  | operation symbol code_bits code_length bit_in
//   result  | result_valid/result_stall| is_symbol bit_out symbol_out last overflow
//
// Sequencing: a table write is done as the back end pops it. An encode issues
// the table read and captures it, then emits its code bits one by one as
// result_stall allows. A decode bit scans the code table through its single
// RAM read port, one entry per cycle in symbol order after a priming read;
// the scan stops at the first match. A decode bit on a full accumulator
// clears it and emits an overflow result.
// Reset: synchronous; the table is empty right after reset through one
// valid flag per entry, so there is no clearing pass.
// Stalls: a two-deep command queue lets the front keep taking items while
// the back end waits on result_stall; item_stall rises only when it is full.
module table_huffman_codec #(
  parameter int MAX_CODE_LEN = thc_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = thc_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [thc_pkg::OP_W-1:0]   operation,
  input  logic [thc_pkg::SYM_W-1:0]  symbol,
  input  logic [thc_pkg::CODE_W-1:0] code_bits,
  input  logic [thc_pkg::LEN_W-1:0]  code_length,
  input  logic                       bit_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       is_symbol,
  output logic                       bit_out,
  output logic [thc_pkg::SYM_W-1:0]  symbol_out,
  output logic                       last,
  output logic                       overflow
);
  import thc_pkg::*;

  // Commands cross from front to back through the queue
  logic push;
  cmd_t push_cmd;
  cmd_t q_head;
  logic q_full;
  logic q_empty;
  logic pop;

  // Classify and drop transactions that leave no trace
  thc_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .operation   (operation),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .bit_in      (bit_in),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  thc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Execute commands in order; hold results until taken
  thc_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_symbol    (is_symbol),
    .bit_out      (bit_out),
    .symbol_out   (symbol_out),
    .last         (last),
    .overflow     (overflow)
  );

endmodule

// ===== src/thc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the table Huffman codec, bound to its top level.
// Uses thc_pkg for field widths.
module thc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic [thc_pkg::OP_W-1:0]   operation,
  input logic [thc_pkg::SYM_W-1:0]  symbol,
  input logic [thc_pkg::CODE_W-1:0] code_bits,
  input logic [thc_pkg::LEN_W-1:0]  code_length,
  input logic                       bit_in,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic                       is_symbol,
  input logic                       bit_out,
  input logic [thc_pkg::SYM_W-1:0]  symbol_out,
  input logic                       last,
  input logic                       overflow
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A decoded symbol carries no bit, end mark or error
  a_symbol_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_symbol |-> !bit_out && !last && !overflow)
    else $error("symbol result carries encoder fields");

  // An overflow result carries nothing else
  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> !is_symbol && !bit_out && !last &&
                                 symbol_out == 8'd0)
    else $error("overflow result carries other fields");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(is_symbol) &&
      $stable(bit_out) && $stable(symbol_out) && $stable(last) &&
      $stable(overflow))
    else $error("stalled result changed");

  // A stalled input transaction holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(operation) &&
      $stable(symbol) && $stable(code_bits) && $stable(code_length) &&
      $stable(bit_in))
    else $error("stalled input transaction changed");

endmodule

bind table_huffman_codec thc_checker u_thc_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for table_huffman_codec: a directed table, then random
// codebook traffic checked against an in-bench prediction of the codec.
// Depends on thc_pkg and the table_huffman_codec RTL.
module tb_top;
  import thc_pkg::*;

  localparam int MAX_LEN        = DEF_MAX_CODE_LEN;
  localparam int NSYM           = DEF_SYMBOL_COUNT;
  // Longest code the table accepts: codes are CODE_W bits wide.
  localparam int LONGEST        = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
  localparam int RANDOM_ITEMS   = 150;
  localparam int QUIET_TAIL     = 30;
  localparam int HOLD_CYCLES    = 150;
  // A decode bit may scan the whole table before it answers.
  localparam int DRAIN_CYCLES   = NSYM + 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic             is_sym;
    logic             code_bit;
    logic [SYM_W-1:0] sym;
    logic             last_bit;
    logic             ovf;
  } codec_out_t;

  // One row of the directed table. Rows with typed set carry their expected
  // output by hand (no output when n_typed is zero); the rest are predicted.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              b;
    logic              typed;
    logic              n_typed;
    codec_out_t        res;
  } dir_row_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  logic [OP_W-1:0]   operation    = OP_NONE;
  logic [SYM_W-1:0]  symbol       = '0;
  logic [CODE_W-1:0] code_bits    = '0;
  logic [LEN_W-1:0]  code_length  = '0;
  logic              bit_in       = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              is_symbol;
  logic              bit_out;
  logic [SYM_W-1:0]  symbol_out;
  logic              last;
  logic              overflow;

  // Predicted codec state: code table plus decode accumulator.
  logic [CODE_W-1:0] table_code [NSYM];
  logic [LEN_W-1:0]  table_len  [NSYM];
  logic [CODE_W-1:0] acc_bits  = '0;
  int                acc_count = 0;

  codec_out_t expected_outputs [$];
  dir_row_t   dir_rows [$];

  // Current random codebook: symbols, codes and lengths in load order.
  logic [SYM_W-1:0]  book_sym  [$];
  logic [CODE_W-1:0] book_code [$];
  int                book_len  [$];

  int mismatch_count      = 0;
  int items_sent          = 0;
  int overflows_predicted = 0;
  int code_bits_seen      = 0;
  int symbols_seen        = 0;
  int overflows_seen      = 0;
  int input_held_cycles   = 0;
  int stuck_cycles        = 0;
  int quiet_from          = 32'h7fff_ffff;
  bit quiet               = 1'b0;
  bit hold_req            = 1'b0;
  bit hold_done           = 1'b0;
  int hold_left           = 0;
  int burst_left          = 0;

  codec_out_t got_out;
  codec_out_t want_out;

  always #10 clk = ~clk;

  table_huffman_codec #(
    .MAX_CODE_LEN (MAX_LEN),
    .SYMBOL_COUNT (NSYM)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .symbol       (symbol),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .bit_in       (bit_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_symbol    (is_symbol),
    .bit_out      (bit_out),
    .symbol_out   (symbol_out),
    .last         (last),
    .overflow     (overflow)
  );

  function automatic codec_out_t make_result(input logic is_sym, input logic code_bit,
                                             input logic [SYM_W-1:0] sym,
                                             input logic last_bit, input logic ovf);
    codec_out_t r;
    r.is_sym   = is_sym;
    r.code_bit = code_bit;
    r.sym      = sym;
    r.last_bit = last_bit;
    r.ovf      = ovf;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Advance the predicted codec by one accepted transaction; queue its
  // outputs unless the caller supplies its own.
  task automatic predict_outputs(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                 input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                 input logic b, input logic keep);
    codec_out_t outs [$];
    logic [63:0] mask;
    logic        hit;
    int          s;
    int          i;
    case (op)
      OP_WRITE: begin
        // Drop writes whose code is too long; clip code bits above the length.
        if (sym < NSYM && len <= LONGEST) begin
          mask = (64'h1 << len) - 64'h1;
          table_code[sym] = code & mask[CODE_W-1:0];
          table_len[sym]  = len;
        end
      end
      OP_ENCODE: begin
        // Emit MSB first; a symbol without an entry emits nothing.
        if (sym < NSYM) begin
          for (i = int'(table_len[sym]) - 1; i >= 0; i--)
            outs = {outs, make_result(1'b0, table_code[sym][i], '0, i == 0, 1'b0)};
        end
      end
      OP_DECODE: begin
        if (acc_count >= LONGEST) begin
          // Full accumulator: flag overflow, clear, drop the arriving bit.
          acc_bits  = '0;
          acc_count = 0;
          overflows_predicted++;
          outs = {outs, make_result(1'b0, 1'b0, '0, 1'b0, 1'b1)};
        end else begin
          acc_bits = {acc_bits[CODE_W-2:0], b};
          acc_count++;
          hit = 1'b0;
          // Lowest matching symbol wins.
          for (s = 0; s < NSYM; s++) begin
            if (!hit && int'(table_len[s]) == acc_count && table_code[s] == acc_bits) begin
              hit = 1'b1;
              outs = {outs, make_result(1'b1, 1'b0, s[SYM_W-1:0], 1'b0, 1'b0)};
            end
          end
          if (hit) begin
            acc_bits  = '0;
            acc_count = 0;
          end
        end
      end
      default: ;
    endcase
    if (keep) begin
      expected_outputs = {expected_outputs, outs};
    end
  endtask

  // Would this decode bit complete a table entry?
  function automatic logic would_match(input logic b);
    logic [CODE_W-1:0] nxt;
    logic              hit;
    hit = 1'b0;
    if (acc_count < LONGEST) begin
      nxt = {acc_bits[CODE_W-2:0], b};
      for (int s = 0; s < NSYM; s++)
        if (int'(table_len[s]) == acc_count + 1 && table_code[s] == nxt) hit = 1'b1;
    end
    return hit;
  endfunction

  // Drive one transaction at the rising edge, hold it until accepted, then
  // advance the prediction. Outside the quiet tail, sometimes insert a short random gap first.
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                            input logic b, input logic keep);
    quiet = (items_sent >= quiet_from);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid  <= 1'b1;
    operation   <= op;
    symbol      <= sym;
    code_bits   <= code;
    code_length <= len;
    bit_in      <= b;
    do @(posedge clk); while (item_stall);
    items_sent++;
    predict_outputs(op, sym, code, len, b, keep);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                         input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                         input logic b, input logic typed, input logic n_typed,
                         input codec_out_t res);
    dir_row_t r;
    r.op      = op;
    r.sym     = sym;
    r.code    = code;
    r.len     = len;
    r.b       = b;
    r.typed   = typed;
    r.n_typed = n_typed;
    r.res     = res;
    dir_rows = {dir_rows, r};
  endtask

  function automatic bit in_book(input logic [SYM_W-1:0] s);
    bit found;
    found = 1'b0;
    foreach (book_sym[i]) if (book_sym[i] == s) found = 1'b1;
    return found;
  endfunction

  // Remove the previous codebook and load a new, incomplete comb-shaped one:
  // entry i is the first i path bits followed by the inverted next path bit,
  // so the path itself never matches and overflow stays reachable.
  task automatic load_codebook(input int k);
    logic [CODE_W-1:0] path;
    logic [CODE_W-1:0] v;
    logic [CODE_W-1:0] cb;
    logic [SYM_W-1:0]  s;
    int                i;
    int                j;
    foreach (book_sym[i])
      offer_item(OP_WRITE, book_sym[i], $urandom, '0, $urandom_range(0, 1), 1'b1);
    book_sym.delete();
    book_code.delete();
    book_len.delete();
    path = $urandom;
    for (i = 0; i < k; i++) begin
      do s = $urandom_range(0, NSYM - 1); while (in_book(s));
      v = '0;
      for (j = 0; j < i; j++) v = {v[CODE_W-2:0], path[j]};
      v = {v[CODE_W-2:0], ~path[i]};
      // Put junk above the length to check that it is clipped.
      cb = (i + 1 >= CODE_W) ? v : (v | ($urandom << (i + 1)));
      offer_item(OP_WRITE, s, cb, LEN_W'(i + 1), $urandom_range(0, 1), 1'b1);
      book_sym  = {book_sym, s};
      book_code = {book_code, v};
      book_len  = {book_len, i + 1};
    end
  endtask

  // Send one codeword as decode bits; optionally flip one bit to break it.
  task automatic decode_codeword(input int idx, input bit broken);
    int flip;
    flip = broken ? $urandom_range(0, book_len[idx] - 1) : -1;
    for (int j = book_len[idx] - 1; j >= 0; j--)
      offer_item(OP_DECODE, $urandom, $urandom, $urandom, book_code[idx][j] ^ (j == flip),
                 1'b1);
  endtask

  // Steer decode bits away from every entry until the accumulator overflows.
  task automatic overflow_run();
    int   start;
    int   tries;
    logic b;
    start = overflows_predicted;
    tries = 0;
    while (overflows_predicted == start && tries < 40) begin
      b = $urandom_range(0, 1);
      if (would_match(b)) b = ~b;
      offer_item(OP_DECODE, $urandom, $urandom, $urandom, b, 1'b1);
      tries++;
    end
  endtask

  // Result side: check every result taken, then pick the next stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got_out = make_result(is_symbol, bit_out, symbol_out, last, overflow);
        if (got_out.ovf === 1'b1) overflows_seen++;
        else if (got_out.is_sym === 1'b1) symbols_seen++;
        else code_bits_seen++;
        if (expected_outputs.size() == 0) begin
          note_failure($sformatf("unexpected output: is_symbol=%0b bit=%0b sym=%02h last=%0b ovf=%0b",
                                 got_out.is_sym, got_out.code_bit, got_out.sym,
                                 got_out.last_bit, got_out.ovf));
        end else begin
          want_out = expected_outputs.pop_front();
          if (got_out.is_sym !== want_out.is_sym || got_out.code_bit !== want_out.code_bit ||
              got_out.sym !== want_out.sym || got_out.last_bit !== want_out.last_bit ||
              got_out.ovf !== want_out.ovf)
            note_failure($sformatf({"output differs: expected is_symbol=%0b bit=%0b sym=%02h ",
                                    "last=%0b ovf=%0b, got %0b %0b %02h %0b %0b"},
                                   want_out.is_sym, want_out.code_bit, want_out.sym,
                                   want_out.last_bit, want_out.ovf, got_out.is_sym,
                                   got_out.code_bit, got_out.sym, got_out.last_bit,
                                   got_out.ovf));
        end
      end
      // Long hold-off once on request, then short random bursts; none in the tail.
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else if (burst_left > 0) begin
        result_stall <= 1'b1;
        burst_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for long.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_stall) input_held_cycles++;
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("table_huffman_codec: mismatch");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t   r;
    codec_out_t none;
    int         stop_at;
    int         phase;
    int         k;
    int         a;
    int         n_actions;
    int         pick;
    int         idx;
    none = '0;
    for (int s = 0; s < NSYM; s++) begin
      table_code[s] = '0;
      table_len[s]  = '0;
    end

    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty table, extremes, clipping, rejected lengths,
    // entry removal, lowest-symbol tie break, and the unused operation.
    add_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 1'b1, 1'b0, none);
    add_row(OP_DECODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, 1'b0, none);
    add_row(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0, none);
    add_row(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h00, 32'h0, 6'd1, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h01, 32'hFFFF_FFFE, 6'd2, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h02, 32'h1, 6'd33, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h03, 32'h5, 6'd63, 1'b1, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h07, 32'h0, 6'd2, 1'b0, 1'b0, 1'b0, none);
    // Second zero bit completes "00": symbol 7 is the only two-bit zero code.
    add_row(OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b0, 1'b1, 1'b1,
            make_result(1'b1, 1'b0, 8'h07, 1'b0, 1'b0));
    add_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 1'b1, 1'b1,
            make_result(1'b0, 1'b0, 8'h00, 1'b1, 1'b0));
    add_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0, 1'b1, 1'b0, none);
    add_row(OP_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h09, 32'h1, 6'd1, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h04, 32'hFFFF_FFFF, 6'd1, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1, 1'b1, 1'b1,
            make_result(1'b1, 1'b0, 8'h04, 1'b0, 1'b0));
    add_row(OP_WRITE, 8'h04, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_DECODE, 8'h00, 32'h0, 6'd0, 1'b1, 1'b1, 1'b1,
            make_result(1'b1, 1'b0, 8'h09, 1'b0, 1'b0));
    add_row(OP_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0, 1'b1, 1'b0, none);
    add_row(OP_DECODE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, 1'b1,
            make_result(1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    add_row(OP_ENCODE, 8'h07, 32'h0, 6'd0, 1'b0, 1'b0, 1'b0, none);
    // Drop both one-bit codes so decode bits can run up to an overflow.
    add_row(OP_WRITE, 8'h00, 32'h0, 6'd0, 1'b0, 1'b0, 1'b0, none);
    add_row(OP_WRITE, 8'h09, 32'h1, 6'd0, 1'b0, 1'b0, 1'b0, none);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      offer_item(r.op, r.sym, r.code, r.len, r.b, !r.typed);
      if (r.typed && r.n_typed) expected_outputs = {expected_outputs, r.res};
    end

    // Random part: load a codebook per phase, then mostly well-formed encode
    // and decode traffic, with broken codewords and noise mixed in.
    stop_at    = items_sent + RANDOM_ITEMS;
    quiet_from = stop_at - QUIET_TAIL;
    for (phase = 0; items_sent < stop_at; phase++) begin
      k = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 32) : $urandom_range(2, 8);
      load_codebook(k);
      // Realign the accumulator so codewords decode from a clean start.
      while (acc_count != 0)
        offer_item(OP_DECODE, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b1);
      if (phase == 0 || phase == 3) overflow_run();
      if (phase == 0) begin
        // Hold the result side while long encodes keep coming, to fill the queue.
        hold_req = 1'b1;
        repeat (6)
          offer_item(OP_ENCODE, book_sym[book_sym.size() - 1], $urandom, $urandom, 1'b0, 1'b1);
      end
      n_actions = $urandom_range(10, 18);
      for (a = 0; a < n_actions && items_sent < stop_at; a++) begin
        pick = $urandom_range(0, 19);
        idx  = $urandom_range(0, book_sym.size() - 1);
        if (pick < 10)
          decode_codeword(idx, pick == 0);
        else if (pick < 14)
          offer_item(OP_ENCODE, book_sym[idx], $urandom, $urandom, $urandom_range(0, 1), 1'b1);
        else if (pick < 16)
          offer_item(OP_ENCODE, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b1);
        else if (pick == 16)
          offer_item(OP_WRITE, $urandom, $urandom, $urandom_range(0, 63), $urandom_range(0, 1),
                     1'b1);
        else if (pick == 17)
          offer_item(OP_NONE, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b1);
        else
          offer_item(OP_DECODE, $urandom, $urandom, $urandom, $urandom_range(0, 1), 1'b1);
      end
    end
    item_valid <= 1'b0;

    // Drain: wait for every expected output, then a full table scan more.
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions in: %0d code bits, %0d decoded symbols, %0d overflows",
             items_sent, code_bits_seen, symbols_seen, overflows_seen);
    $display("input side held back by the codec for %0d cycles", input_held_cycles);
    if (mismatch_count == 0)
      $display("table_huffman_codec: match");
    else
      $display("table_huffman_codec: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
src/thc_pkg.sv
src/thc_ram.sv
src/thc_front.sv
src/thc_queue.sv
src/thc_back.sv
src/table_huffman_codec.sv
src/thc_checker.sv
tb/tb_top.sv
